[rtl/mti_pkg.sv]
// Shared types and constants of the multilinear table interpolator.
`timescale 1ns / 1ps

package mti_pkg;

  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int DIFF_W     = VAL_W + 1;
  localparam int NUM_W      = DIFF_W + FRAC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [1:0] OP_WR_BP   = 2'd0;
  localparam logic [1:0] OP_WR_GRID = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;
  localparam logic [1:0] OP_RSVD    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PTS0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PTS1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PTS2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PTS3 = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         dim_select;
    logic [11:0]        address;
    logic signed [31:0] write_value;
    logic signed [31:0] pos_0;
    logic signed [31:0] pos_1;
    logic signed [31:0] pos_2;
    logic signed [31:0] pos_3;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               out_of_span;
  } out_item_t;

endpackage

[rtl/mti_div.sv]
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module mti_div #(
  parameter int NW = 49,
  parameter int DW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 done,
  output logic signed [NW:0]   quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dmag_r, dmag_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, q_r[NW-1]};
  assign ge     = (rem_sh >= {1'b0, dmag_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = num[NW-1] ? NW'(-num) : NW'(num);
      dmag_nxt = den[DW-1] ? DW'(-den) : DW'(den);
      neg_nxt  = num[NW-1] ^ den[DW-1];
    end else if (busy_r) begin
      rem_nxt = ge ? DW'(rem_sh - {1'b0, dmag_r}) : rem_sh[DW-1:0];
      q_nxt   = {q_r[NW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

[rtl/multilinear_table_interpolator.sv]
// Top level of the multilinear table interpolator: memories, sequencer and blend datapath.
`timescale 1ns / 1ps

// A transaction on the input side is taken when start is high and busy is low. Breakpoint
// and grid writes are absorbed in that same cycle and keep busy low, so they can stream
// one per cycle. A lookup raises busy until its single result has been shown on out_item
// for one cycle with out_strobe high; the receiver cannot stall, so take it then. The
// result strobe and busy falling happen in the same cycle, and a new transaction may be
// offered right then. Busy stays high while the lookup scans the breakpoints of each
// dimension in use, one memory read per breakpoint, forms each interval ratio in the
// one-bit-per-cycle divider, and gathers the grid corners into the corner memory, where
// each blend reads two corners, multiplies in two halves and writes back; a dimension
// whose two enclosing breakpoints are equal skips the divider. Configuration registers
// are to be written only while busy is low; the block itself does not enforce this.

module multilinear_table_interpolator #(
  parameter int MAX_DIMS   = 4,
  parameter int MAX_POINTS = 8,
  parameter int GRID_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  mti_pkg::in_item_t               in_item,
  output logic                            out_strobe,
  output mti_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [mti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mti_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int BP_DEPTH = MAX_DIMS * MAX_POINTS;
  localparam int BP_AW    = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;
  localparam int GAW      = $clog2(GRID_DEPTH);
  localparam int PW       = $clog2(MAX_POINTS + 1);
  localparam int DW       = $clog2(MAX_DIMS + 1);
  localparam int DIW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int FULL_W   = MAX_DIMS * $clog2(MAX_POINTS) + 1;
  localparam int AW       = (FULL_W > 18) ? FULL_W : 18;
  localparam int NCORN    = 1 << MAX_DIMS;
  localparam int CAW      = MAX_DIMS;
  localparam int CCW      = MAX_DIMS + 1;
  localparam int VW       = mti_pkg::VAL_W;
  localparam int NW       = mti_pkg::NUM_W;
  localparam int XW       = mti_pkg::DIFF_W;
  localparam int PRW      = VW + 17;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SCAN = 4'd1;
  localparam logic [3:0] ST_LO   = 4'd2;
  localparam logic [3:0] ST_HI   = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_NEXT = 4'd5;
  localparam logic [3:0] ST_CORN = 4'd6;
  localparam logic [3:0] ST_BRD  = 4'd7;
  localparam logic [3:0] ST_BM1  = 4'd8;
  localparam logic [3:0] ST_BM2  = 4'd9;
  localparam logic [3:0] ST_BM3  = 4'd10;
  localparam logic [3:0] ST_BSUM = 4'd11;
  localparam logic [3:0] ST_BADD = 4'd12;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  function automatic logic signed [VW-1:0] sat_val(input logic signed [63:0] v);
    logic signed [VW-1:0] r;
    if (v > SAT_HI) r = SAT_HI[VW-1:0];
    else if (v < SAT_LO) r = SAT_LO[VW-1:0];
    else r = v[VW-1:0];
    return r;
  endfunction

  // Memories.
  logic signed [VW-1:0] bp_mem   [BP_DEPTH];
  logic signed [VW-1:0] grid_mem [GRID_DEPTH];
  logic signed [VW-1:0] cm_mem   [NCORN];

  logic signed [VW-1:0] bp_rdata_r, grid_rdata_r, ca_r, cb_r;

  // Control and datapath registers.
  logic [3:0]             state_r, state_nxt;
  mti_pkg::in_item_t      item_r, item_nxt;
  logic [2:0]             dims_r, dims_nxt;
  logic [3:0]             pts_r [4];
  logic [3:0]             pts_nxt [4];
  logic                   loaded_r, loaded_nxt;
  logic [DIW-1:0]         d_r, d_nxt;
  logic [PW-1:0]          rq_r, rq_nxt;
  logic                   pv_r, pv_nxt;
  logic [PW-1:0]          pk_r, pk_nxt;
  logic [PW-1:0]          cnt_r, cnt_nxt;
  logic                   outside_r, outside_nxt;
  logic signed [VW-1:0]   lo_r, lo_nxt;
  logic [AW-1:0]          acc_r, acc_nxt;
  logic [AW-1:0]          base_r, base_nxt;
  logic [AW-1:0]          stride_r [MAX_DIMS];
  logic [AW-1:0]          stride_nxt [MAX_DIMS];
  logic signed [VW-1:0]   ratio_r [MAX_DIMS];
  logic signed [VW-1:0]   ratio_nxt [MAX_DIMS];
  logic [CCW-1:0]         cq_r, cq_nxt;
  logic                   cpv_r, cpv_nxt;
  logic [CCW-1:0]         cpc_r, cpc_nxt;
  logic                   cok_r, cok_nxt;
  logic [DIW-1:0]         bd_r, bd_nxt;
  logic [CAW-1:0]         bj_r, bj_nxt;
  logic signed [XW-1:0]   diff_r, diff_nxt;
  logic signed [VW-1:0]   vlo_r, vlo_nxt;
  logic signed [PRW-1:0]  p1_r, p1_nxt;
  logic signed [PRW-1:0]  p2_r, p2_nxt;
  logic signed [PRW+15:0] prod_r, prod_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  mti_pkg::out_item_t     out_item_r, out_item_nxt;

  // Combinational helpers.
  logic                  acc_in;
  logic                  bp_we, g_we;
  logic [BP_AW-1:0]      bp_waddr, bp_raddr;
  logic [GAW-1:0]        g_waddr;
  logic                  bp_re, g_re, cm_re, cm_we;
  logic [PW-1:0]         bp_ridx;
  logic [CAW-1:0]        cm_waddr, cm_kaddr;
  logic signed [VW-1:0]  cm_wdata;
  logic [DW-1:0]         nd;
  logic [PW-1:0]         n_cur;
  logic signed [VW-1:0]  x_cur;
  logic signed [VW-1:0]  ratio_cur;
  logic [CCW-1:0]        ncorn;
  logic [AW-1:0]         c_addr;
  logic [CAW-1:0]        k_cur;
  logic signed [XW-1:0]  dx, den;
  logic signed [NW-1:0]  div_num;
  logic                  div_start, div_done;
  logic signed [NW:0]    div_quo;
  logic signed [PRW+1:0] blend_sum;
  logic signed [VW-1:0]  blend_val;

  assign acc_in = start && !busy;

  // Transactions that only write a table are absorbed in the accept cycle.
  assign bp_we = acc_in && (in_item.operation == mti_pkg::OP_WR_BP)
               && (int'(in_item.dim_select) < MAX_DIMS)
               && (int'(in_item.address) < MAX_POINTS);
  assign bp_waddr = BP_AW'(int'(in_item.dim_select) * MAX_POINTS + int'(in_item.address));
  assign g_we = acc_in && (in_item.operation == mti_pkg::OP_WR_GRID)
              && (int'(in_item.address) < GRID_DEPTH);
  assign g_waddr = GAW'(int'(in_item.address));

  // Register values are clamped into their meaningful ranges.
  always_comb begin
    int t;
    t = int'(dims_r);
    if (t < 1) t = 1;
    if (t > MAX_DIMS) t = MAX_DIMS;
    nd = DW'(t);
  end

  always_comb begin
    int p;
    p = 2;
    x_cur = '0;
    for (int i = 0; i < 4; i++) begin
      if (int'(d_r) == i) p = int'(pts_r[i]);
    end
    if (int'(d_r) == 0) x_cur = item_r.pos_0;
    if (int'(d_r) == 1) x_cur = item_r.pos_1;
    if (int'(d_r) == 2) x_cur = item_r.pos_2;
    if (int'(d_r) == 3) x_cur = item_r.pos_3;
    if (p < 2) p = 2;
    if (p > MAX_POINTS) p = MAX_POINTS;
    n_cur = PW'(p);
  end

  assign bp_raddr = BP_AW'(int'(d_r) * MAX_POINTS + int'(bp_ridx));
  assign ncorn    = CCW'(1) << nd;
  assign k_cur    = CAW'(1) << bd_r;
  assign cm_kaddr = bj_r + k_cur;
  assign ratio_cur = ratio_r[bd_r];

  // Flat grid address of the corner numbered cq_r: bit d of the corner number steps
  // one breakpoint up in dimension d.
  always_comb begin
    logic [AW-1:0] off;
    off = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (i < int'(nd) && cq_r[i]) off = off + stride_r[i];
    end
    c_addr = base_r + off;
  end

  assign dx      = {x_cur[VW-1], x_cur} - {lo_r[VW-1], lo_r};
  assign den     = {bp_rdata_r[VW-1], bp_rdata_r} - {lo_r[VW-1], lo_r};
  assign div_num = {dx, {mti_pkg::FRAC_W{1'b0}}};

  // The product shifted right by sixteen is the floor of the Q16.16 scaling.
  assign blend_sum = (PRW + 2)'(vlo_r) + (PRW + 2)'($signed(prod_r[PRW+15:16]));
  assign blend_val = sat_val(64'(blend_sum));

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    dims_nxt       = dims_r;
    pts_nxt        = pts_r;
    loaded_nxt     = loaded_r;
    d_nxt          = d_r;
    rq_nxt         = rq_r;
    pv_nxt         = 1'b0;
    pk_nxt         = pk_r;
    cnt_nxt        = cnt_r;
    outside_nxt    = outside_r;
    lo_nxt         = lo_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    stride_nxt     = stride_r;
    ratio_nxt      = ratio_r;
    cq_nxt         = cq_r;
    cpv_nxt        = 1'b0;
    cpc_nxt        = cpc_r;
    cok_nxt        = cok_r;
    bd_nxt         = bd_r;
    bj_nxt         = bj_r;
    diff_nxt       = diff_r;
    vlo_nxt        = vlo_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    prod_nxt       = prod_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    bp_re          = 1'b0;
    bp_ridx        = rq_r;
    g_re           = 1'b0;
    cm_re          = 1'b0;
    cm_we          = 1'b0;
    cm_waddr       = bj_r;
    cm_wdata       = blend_val;
    div_start      = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        mti_pkg::REG_DIMS: dims_nxt   = cfg_wdata[2:0];
        mti_pkg::REG_PTS0: pts_nxt[0] = cfg_wdata;
        mti_pkg::REG_PTS1: pts_nxt[1] = cfg_wdata;
        mti_pkg::REG_PTS2: pts_nxt[2] = cfg_wdata;
        mti_pkg::REG_PTS3: pts_nxt[3] = cfg_wdata;
        default: ;
      endcase
    end
    if (g_we) loaded_nxt = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (acc_in && in_item.operation == mti_pkg::OP_LOOKUP) begin
          item_nxt    = in_item;
          d_nxt       = '0;
          rq_nxt      = '0;
          cnt_nxt     = '0;
          outside_nxt = 1'b0;
          acc_nxt     = AW'(1);
          base_nxt    = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // One breakpoint read per cycle; the data is checked in the following cycle.
        if (rq_r < n_cur) begin
          bp_re  = 1'b1;
          rq_nxt = rq_r + 1'b1;
          pv_nxt = 1'b1;
          pk_nxt = rq_r;
        end
        if (pv_r) begin
          if (pk_r == '0 && x_cur < bp_rdata_r) outside_nxt = 1'b1;
          if (pk_r == n_cur - 1'b1 && x_cur > bp_rdata_r) outside_nxt = 1'b1;
          if (pk_r != '0 && pk_r < n_cur - 1'b1 && x_cur >= bp_rdata_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (pk_r == n_cur - 1'b1) begin
            bp_re     = 1'b1;
            bp_ridx   = cnt_r;
            pv_nxt    = 1'b0;
            state_nxt = ST_LO;
          end
        end
      end
      ST_LO: begin
        lo_nxt    = bp_rdata_r;
        bp_re     = 1'b1;
        bp_ridx   = cnt_r + 1'b1;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        if (den == '0) begin
          ratio_nxt[d_r] = '0;
          state_nxt      = ST_NEXT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ratio_nxt[d_r] = sat_val(64'(div_quo));
          state_nxt      = ST_NEXT;
        end
      end
      ST_NEXT: begin
        stride_nxt[d_r] = acc_r;
        base_nxt        = base_r + AW'(AW'(cnt_r) * acc_r);
        acc_nxt         = AW'(acc_r * AW'(n_cur));
        if (DW'(d_r) == nd - DW'(1)) begin
          cq_nxt    = '0;
          state_nxt = ST_CORN;
        end else begin
          d_nxt     = d_r + 1'b1;
          rq_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_CORN: begin
        if (cq_r < ncorn) begin
          g_re    = 1'b1;
          cq_nxt  = cq_r + 1'b1;
          cpv_nxt = 1'b1;
          cpc_nxt = cq_r;
          cok_nxt = (c_addr < AW'(GRID_DEPTH));
        end
        if (cpv_r) begin
          cm_we    = 1'b1;
          cm_waddr = cpc_r[CAW-1:0];
          cm_wdata = cok_r ? grid_rdata_r : '0;
          if (cpc_r == ncorn - 1'b1) begin
            bd_nxt    = DIW'(nd - DW'(1));
            bj_nxt    = '0;
            state_nxt = ST_BRD;
          end
        end
      end
      ST_BRD: begin
        cm_re     = 1'b1;
        state_nxt = ST_BM1;
      end
      ST_BM1: begin
        diff_nxt  = {cb_r[VW-1], cb_r} - {ca_r[VW-1], ca_r};
        vlo_nxt   = ca_r;
        state_nxt = ST_BM2;
      end
      ST_BM2: begin
        p1_nxt    = PRW'(ratio_cur) * PRW'($signed({1'b0, diff_r[15:0]}));
        state_nxt = ST_BM3;
      end
      ST_BM3: begin
        p2_nxt    = PRW'(ratio_cur) * PRW'($signed(diff_r[XW-1:16]));
        state_nxt = ST_BSUM;
      end
      ST_BSUM: begin
        prod_nxt  = {p2_r, 16'b0} + (PRW + 16)'(p1_r);
        state_nxt = ST_BADD;
      end
      ST_BADD: begin
        cm_we    = 1'b1;
        cm_waddr = bj_r;
        cm_wdata = blend_val;
        if (bj_r == k_cur - 1'b1) begin
          if (bd_r == '0) begin
            out_strobe_nxt            = 1'b1;
            out_item_nxt.result_value = loaded_r ? blend_val : '0;
            out_item_nxt.out_of_span  = outside_r;
            state_nxt                 = ST_IDLE;
          end else begin
            bd_nxt    = bd_r - 1'b1;
            bj_nxt    = '0;
            state_nxt = ST_BRD;
          end
        end else begin
          bj_nxt    = bj_r + 1'b1;
          state_nxt = ST_BRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bp_we) bp_mem[bp_waddr] <= in_item.write_value;
    if (bp_re) bp_rdata_r <= bp_mem[bp_raddr];
  end

  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_waddr] <= in_item.write_value;
    if (g_re) grid_rdata_r <= grid_mem[c_addr[GAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cm_mem[cm_waddr] <= cm_wdata;
    if (cm_re) begin
      ca_r <= cm_mem[bj_r];
      cb_r <= cm_mem[cm_kaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dims_r       <= 3'd1;
      pts_r        <= '{default: 4'd2};
      loaded_r     <= 1'b0;
      pv_r         <= 1'b0;
      cpv_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dims_r       <= dims_nxt;
      pts_r        <= pts_nxt;
      loaded_r     <= loaded_nxt;
      pv_r         <= pv_nxt;
      cpv_r        <= cpv_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    item_r     <= item_nxt;
    d_r        <= d_nxt;
    rq_r       <= rq_nxt;
    pk_r       <= pk_nxt;
    cnt_r      <= cnt_nxt;
    outside_r  <= outside_nxt;
    lo_r       <= lo_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    stride_r   <= stride_nxt;
    ratio_r    <= ratio_nxt;
    cq_r       <= cq_nxt;
    cpc_r      <= cpc_nxt;
    cok_r      <= cok_nxt;
    bd_r       <= bd_nxt;
    bj_r       <= bj_nxt;
    diff_r     <= diff_nxt;
    vlo_r      <= vlo_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    prod_r     <= prod_nxt;
    out_item_r <= out_item_nxt;
  end

  mti_div #(
    .NW(NW),
    .DW(XW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef ASSERT_OFF
  // A result closes its lookup: busy drops in the same cycle the strobe shows.
  a_strobe_ends_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy && $past(busy)))
    else $error("result strobe without a lookup in flight");

  // An accepted lookup always occupies the block on the next cycle.
  a_lookup_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation == mti_pkg::OP_LOOKUP) |=> busy)
    else $error("lookup accepted but block not busy");

  // The divider finishes only while the sequencer waits on it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the ratio wait");

  // The corner memory is written only while gathering corners or writing back a blend.
  a_cm_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cm_we |-> (state_r == ST_CORN || state_r == ST_BADD))
    else $error("corner memory written in the wrong phase");
`endif

endmodule

[tb/sv/mti_checker.sv]
// Checker for the multilinear table interpolator: tracks state, predicts lookups, compares.
`timescale 1ns / 1ps

module mti_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  mti_pkg::in_item_t              in_item,
  input  logic                           out_strobe,
  input  mti_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [mti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mti_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             errors,
  output int                             pending
);

  logic signed [31:0] bp_mem [32];
  logic signed [31:0] grid_mem [4096];
  bit                 grid_loaded;
  logic [3:0]         reg_file [5];
  mti_pkg::out_item_t lookup_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Expected outcome of one lookup against the current table and registers.
  function automatic mti_pkg::out_item_t interpolate(mti_pkg::in_item_t it);
    int                 nd, n, i, d, j, k, c;
    longint             x, lo, hi, den, s, a;
    int                 cell_idx [4];
    longint             ratio [4];
    longint             stride [4];
    longint             v [16];
    bit                 outside;
    mti_pkg::out_item_t res;
    nd = reg_file[0];
    if (nd < 1) nd = 1;
    if (nd > 4) nd = 4;
    outside = 0;
    s = 1;
    for (d = 0; d < nd; d++) begin
      n = reg_file[1 + d];
      if (n < 2) n = 2;
      if (n > 8) n = 8;
      case (d)
        0: x = it.pos_0;
        1: x = it.pos_1;
        2: x = it.pos_2;
        default: x = it.pos_3;
      endcase
      i = 0;
      for (j = 1; j + 1 < n; j++)
        if (x >= longint'(bp_mem[d * 8 + j])) i++;
      if (x < longint'(bp_mem[d * 8]) || x > longint'(bp_mem[d * 8 + n - 1])) outside = 1;
      lo = bp_mem[d * 8 + i];
      hi = bp_mem[d * 8 + i + 1];
      den = hi - lo;
      ratio[d] = (den == 0) ? 0 : sat32(((x - lo) * 65536) / den);
      cell_idx[d] = i;
      stride[d] = s;
      s = s * n;
    end
    for (c = 0; c < (1 << nd); c++) begin
      a = 0;
      for (d = 0; d < nd; d++)
        a += (cell_idx[d] + ((c >> d) & 1)) * stride[d];
      v[c] = (a < 4096) ? longint'(grid_mem[a]) : 0;
    end
    // Blend from the highest dimension down; the arithmetic shift is a floor division.
    for (d = nd - 1; d >= 0; d--) begin
      k = 1 << d;
      for (j = 0; j < k; j++)
        v[j] = sat32(v[j] + ((ratio[d] * (v[j + k] - v[j])) >>> 16));
    end
    res.result_value = grid_loaded ? v[0][31:0] : 32'sd0;
    res.out_of_span  = outside;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    mti_pkg::out_item_t want;
    if (!rst_n) begin
      reg_file[0] = 4'd1;
      for (int r = 1; r < 5; r++) reg_file[r] = 4'd2;
      grid_loaded = 0;
      lookup_q.delete();
    end else begin
      if (out_strobe) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("unexpected result, value", out_item.result_value, 0);
        end else begin
          want = lookup_q.pop_front();
          if (out_item.result_value !== want.result_value)
            report_mismatch("result_value", out_item.result_value, want.result_value);
          if (out_item.out_of_span !== want.out_of_span)
            report_mismatch("out_of_span", out_item.out_of_span, want.out_of_span);
        end
      end
      if (start && !busy) begin
        case (in_item.operation)
          mti_pkg::OP_WR_BP: begin
            if (in_item.address < 8)
              bp_mem[in_item.dim_select * 8 + in_item.address] = in_item.write_value;
          end
          mti_pkg::OP_WR_GRID: begin
            grid_mem[in_item.address] = in_item.write_value;
            grid_loaded = 1;
          end
          mti_pkg::OP_LOOKUP: lookup_q.push_back(interpolate(in_item));
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          mti_pkg::REG_DIMS: reg_file[0] = {1'b0, cfg_wdata[2:0]};
          mti_pkg::REG_PTS0: reg_file[1] = cfg_wdata;
          mti_pkg::REG_PTS1: reg_file[2] = cfg_wdata;
          mti_pkg::REG_PTS2: reg_file[3] = cfg_wdata;
          mti_pkg::REG_PTS3: reg_file[4] = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = lookup_q.size();
  end

endmodule

[tb/sv/tb.sv]
// Testbench top of the multilinear table interpolator: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb;

  localparam longint CYCLE_LIMIT = 4_000_000;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  mti_pkg::in_item_t              in_item;
  logic                           out_strobe;
  mti_pkg::out_item_t             out_item;
  logic                           cfg_we;
  logic [mti_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mti_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             errors;
  int                             pending;
  longint                         cycles;

  // Stimulus-side view of the table, used to size the grid loads and aim coordinates near the breakpoint span.
  int                    dims_now;
  int                    pts_now [4];
  longint                bp_shadow [4][8];
  bit                    quiet;

  multilinear_table_interpolator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mti_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // The watchdog ends a hung run; a lookup that never answers lands here too.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic mti_pkg::in_item_t make_item(logic [1:0] op, logic [1:0] dsel,
                                                  logic [11:0] addr, longint wv,
                                                  longint p0, longint p1, longint p2,
                                                  longint p3);
    mti_pkg::in_item_t it;
    it.operation   = op;
    it.dim_select  = dsel;
    it.address     = addr;
    it.write_value = wv[31:0];
    it.pos_0       = p0[31:0];
    it.pos_1       = p1[31:0];
    it.pos_2       = p2[31:0];
    it.pos_3       = p3[31:0];
    return it;
  endfunction

  function automatic longint rand32();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Grid values are mostly moderate so blends stay interesting, sometimes full range.
  function automatic longint rand_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
    if (r < 3) return rand32();
    return longint'($urandom_range(0, 2097152)) - 1048576;
  endfunction

  // Coordinates land mostly in or just around the span, so extrapolation is exercised too.
  function automatic longint rand_pos(int d);
    longint lo, hi, span;
    int     r;
    r = $urandom_range(0, 9);
    if (r == 0) return rand32();
    if (r == 1) return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
    lo = bp_shadow[d][0];
    hi = bp_shadow[d][pts_now[d] - 1];
    if (r == 2) return $urandom_range(0, 1) ? lo : hi;
    span = (hi > lo) ? hi - lo : lo - hi;
    if (lo > hi) lo = hi;
    return clamp32(lo - span / 4 + longint'($urandom()) % (span + span / 2 + 1));
  endfunction

  task automatic send(mti_pkg::in_item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Lets every outstanding lookup come back, then a few spare cycles for the datapath.
  task automatic drain();
    idle(1);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [mti_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[mti_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_bp(int d, int idx, longint v);
    send(make_item(mti_pkg::OP_WR_BP, d[1:0], idx[11:0], v, rand32(), rand32(), rand32(),
                   rand32()));
    if (idx < 8) bp_shadow[d][idx] = v;
  endtask

  task automatic lookup();
    send(make_item(mti_pkg::OP_LOOKUP, 2'($urandom_range(0, 3)),
                   12'($urandom_range(0, 4095)), rand32(),
                   rand_pos(0), rand_pos(1), rand_pos(2), rand_pos(3)));
  endtask

  // Sorted breakpoints: narrow, spread over the whole range, or with repeated points.
  task automatic load_breakpoints(int d);
    int     n, style;
    longint v, step;
    n = pts_now[d];
    style = $urandom_range(0, 5);
    if (style == 0) begin
      for (int j = 0; j < n; j++)
        write_bp(d, j, -64'sd2147483648 + (longint'(j) * 64'sd4294967295) / (n - 1));
    end else begin
      v = longint'($urandom_range(0, 4194304)) - 2097152;
      for (int j = 0; j < n; j++) begin
        write_bp(d, j, v);
        step = (style == 1 && $urandom_range(0, 1)) ? 0 : $urandom_range(1, 524288);
        v = v + step;
      end
    end
  endtask

  // A phase: set the registers while idle, give the table well-formed contents, then
  // stream random transactions with bursts of idling.
  task automatic run_phase(int dims_w, int p0, int p1, int p2, int p3, int count,
                           bit hold_mid, int quiet_from);
    int prod, done, r, d;
    drain();
    write_reg(mti_pkg::REG_DIMS, dims_w);
    write_reg(mti_pkg::REG_PTS0, p0);
    write_reg(mti_pkg::REG_PTS1, p1);
    write_reg(mti_pkg::REG_PTS2, p2);
    write_reg(mti_pkg::REG_PTS3, p3);
    dims_now = dims_w & 7;
    if (dims_now < 1) dims_now = 1;
    if (dims_now > 4) dims_now = 4;
    pts_now[0] = p0; pts_now[1] = p1; pts_now[2] = p2; pts_now[3] = p3;
    prod = 1;
    for (int k = 0; k < 4; k++) begin
      if (pts_now[k] < 2) pts_now[k] = 2;
      if (pts_now[k] > 8) pts_now[k] = 8;
      if (k < dims_now) prod = prod * pts_now[k];
    end
    for (int k = 0; k < dims_now; k++) load_breakpoints(k);
    for (int a = 0; a < prod; a++)
      send(make_item(mti_pkg::OP_WR_GRID, 2'($urandom_range(0, 3)), a[11:0], rand_value(),
                     rand32(), rand32(), rand32(), rand32()));
    done = 0;
    while (done < count) begin
      if (done >= quiet_from) quiet = 1;
      if (!quiet && $urandom_range(0, 3) == 0) idle($urandom_range(1, 16));
      if (hold_mid && done == count / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 70) begin
        lookup();
        done++;
      end else if (r < 80) begin
        send(make_item(mti_pkg::OP_WR_GRID, 2'($urandom_range(0, 3)),
                       $urandom_range(0, 3) == 0 ? 12'($urandom_range(0, 4095))
                                                 : 12'($urandom_range(0, prod - 1)),
                       rand_value(), rand32(), rand32(), rand32(), rand32()));
        done++;
      end else if (r < 90) begin
        d = $urandom_range(0, 3);
        write_bp(d, $urandom_range(0, 7),
                 d < dims_now ? rand_pos(d) : rand32());
        done++;
      end else if (r < 95) begin
        // Breakpoint index beyond the table: the block ignores it.
        write_bp($urandom_range(0, 3), $urandom_range(8, 4095), rand32());
      end else begin
        send(make_item(mti_pkg::OP_RSVD, 2'($urandom_range(0, 3)),
                       12'($urandom_range(0, 4095)), rand32(),
                       rand32(), rand32(), rand32(), rand32()));
      end
    end
  endtask

  initial begin
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    cycles    = 0;
    quiet     = 0;
    dims_now  = 1;
    for (int k = 0; k < 4; k++) pts_now[k] = 2;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under reset settings: one dimension of two points.
    write_bp(0, 0, 0);
    write_bp(0, 1, 64'sd65536);
    // Lookup before any grid transaction answers 0 but still flags the span.
    send(make_item(mti_pkg::OP_LOOKUP, 2'd0, 12'd0, 0, 64'sd131072, 0, 0, 0));
    write_bp(0, 8, 64'sd12345);
    send(make_item(mti_pkg::OP_RSVD, 2'd3, 12'hfff, -1, -1, -1, -1, -1));
    send(make_item(mti_pkg::OP_WR_GRID, 2'd3, 12'hfff, 64'sd2147483647, 0, 0, 0, 0));
    send(make_item(mti_pkg::OP_WR_GRID, 2'd0, 12'd0, -64'sd2147483648, 0, 0, 0, 0));
    send(make_item(mti_pkg::OP_WR_GRID, 2'd0, 12'd1, 64'sd2147483647, 0, 0, 0, 0));
    send(make_item(mti_pkg::OP_LOOKUP, 2'd0, 12'd0, 0, 64'sd32768, 0, 0, 0));
    send(make_item(mti_pkg::OP_LOOKUP, 2'd0, 12'd0, 0, 64'sd2147483647, 0, 0, 0));
    send(make_item(mti_pkg::OP_LOOKUP, 2'd0, 12'd0, 0, -64'sd2147483648, -1, -1, -1));
    send(make_item(mti_pkg::OP_LOOKUP, 2'd0, 12'd0, 0, 0, 0, 0, 0));
    send(make_item(mti_pkg::OP_LOOKUP, 2'd0, 12'd0, 0, 64'sd65536, 0, 0, 0));
    // Equal breakpoints force a zero ratio.
    write_bp(0, 1, 0);
    send(make_item(mti_pkg::OP_LOOKUP, 2'd0, 12'd0, 0, 64'sd5, 0, 0, 0));
    send(make_item(mti_pkg::OP_LOOKUP, 2'd0, 12'd0, 0, -64'sd5, 0, 0, 0));
    send(make_item(mti_pkg::OP_WR_GRID, 2'd0, 12'd0, 64'sd100, 0, 0, 0, 0));
    write_bp(0, 0, -64'sd2147483648);
    write_bp(0, 1, 64'sd2147483647);
    send(make_item(mti_pkg::OP_LOOKUP, 2'd0, 12'd0, 0, 64'sd1, 0, 0, 0));

    // Random phases over several settings, including out-of-range register values.
    run_phase(1, 2, 2, 2, 2, 100, 0, 1000);
    run_phase(1, 8, 3, 3, 3, 100, 0, 1000);
    run_phase(2, 5, 3, 2, 2, 140, 1, 1000);
    run_phase(3, 4, 6, 2, 2, 140, 0, 1000);
    run_phase(4, 2, 2, 2, 2, 140, 0, 1000);
    run_phase(0, 1, 15, 0, 9, 100, 0, 1000);
    run_phase(7, 3, 8, 2, 4, 120, 0, 1000);
    run_phase(4, 4, 4, 3, 3, 150, 0, 0);

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
